FILE: hw/rtl/assert_macros.svh
// assertion macros for the record deframer
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("deframer assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("deframer assertion failed");

`endif

FILE: hw/rtl/trd_pkg.sv
// shared types and constants of the record deframer
package trd_pkg;

	localparam int unsigned CFG_ADDR_W = 3;
	localparam logic        REG_MAX_LEN = 1'b0;
	localparam logic [15:0] MAX_LEN_RESET = 16'd16384;

	localparam logic CMD_BYTE  = 1'b0;
	localparam logic CMD_CLEAR = 1'b1;

	localparam logic [2:0] HDR_TYPE   = 3'd0;
	localparam logic [2:0] HDR_VER_HI = 3'd1;
	localparam logic [2:0] HDR_VER_LO = 3'd2;
	localparam logic [2:0] HDR_LEN_HI = 3'd3;
	localparam logic [2:0] HDR_LEN_LO = 3'd4;

	localparam logic [15:0] VER_MIN = 16'h0301;
	localparam logic [15:0] VER_MAX = 16'h0304;

	typedef enum logic [1:0] {
		PH_HEADER  = 2'd0,
		PH_PAYLOAD = 2'd1,
		PH_ERROR   = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		ST_PAYLOAD = 2'd0,
		ST_EMPTY   = 2'd1,
		ST_REJECT  = 2'd2
	} status_t;

	typedef struct packed {
		status_t     status;
		logic [7:0]  content_type;
		logic [7:0]  data_byte;
		logic        record_last;
		logic [15:0] record_length;
	} trd_result_t;

endpackage

FILE: hw/rtl/trd_parser.sv
// record header parser and fragment pass-through state machine
module trd_parser import trd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic        cmd,
	input  logic [7:0]  in_byte,
	input  logic [15:0] max_len,
	output logic        res_valid,
	output trd_result_t res
);

	phase_t      phase_q, phase_d;
	logic [2:0]  hdr_cnt_q, hdr_cnt_d;
	logic [7:0]  type_q, type_d;
	logic [7:0]  ver_hi_q, ver_hi_d;
	logic [15:0] len_q, len_d;
	logic [15:0] rem_q, rem_d;
	logic [15:0] ver_full;
	logic [15:0] len_full;
	logic [15:0] rem_dec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HEADER;
			hdr_cnt_q <= HDR_TYPE;
			type_q    <= 8'd0;
			ver_hi_q  <= 8'd0;
			len_q     <= 16'd0;
			rem_q     <= 16'd0;
		end else if (step) begin
			phase_q   <= phase_d;
			hdr_cnt_q <= hdr_cnt_d;
			type_q    <= type_d;
			ver_hi_q  <= ver_hi_d;
			len_q     <= len_d;
			rem_q     <= rem_d;
		end
	end

	assign ver_full = {ver_hi_q, in_byte};
	assign len_full = {len_q[7:0], in_byte};
	assign rem_dec  = rem_q - 16'd1;

	always_comb begin
		phase_d   = phase_q;
		hdr_cnt_d = hdr_cnt_q;
		type_d    = type_q;
		ver_hi_d  = ver_hi_q;
		len_d     = len_q;
		rem_d     = rem_q;
		res_valid = 1'b0;
		res.status        = ST_PAYLOAD;
		res.content_type  = type_q;
		res.data_byte     = 8'd0;
		res.record_last   = 1'b1;
		res.record_length = len_q;
		if (cmd == CMD_CLEAR) begin
			phase_d   = PH_HEADER;
			hdr_cnt_d = HDR_TYPE;
			type_d    = 8'd0;
			ver_hi_d  = 8'd0;
			len_d     = 16'd0;
			rem_d     = 16'd0;
		end else begin
			case (phase_q)
				PH_HEADER: begin
					case (hdr_cnt_q)
						HDR_TYPE: begin
							type_d    = in_byte;
							hdr_cnt_d = HDR_VER_HI;
						end
						HDR_VER_HI: begin
							ver_hi_d  = in_byte;
							hdr_cnt_d = HDR_VER_LO;
						end
						HDR_VER_LO: begin
							// keep only the accept flag of the version
							ver_hi_d  = {7'd0, (ver_full >= VER_MIN) && (ver_full <= VER_MAX)};
							hdr_cnt_d = HDR_LEN_HI;
						end
						HDR_LEN_HI: begin
							len_d     = {8'd0, in_byte};
							hdr_cnt_d = HDR_LEN_LO;
						end
						default: begin
							len_d             = len_full;
							hdr_cnt_d         = HDR_TYPE;
							res.record_length = len_full;
							if (ver_hi_q == 8'd0 || len_full > max_len) begin
								phase_d    = PH_ERROR;
								res_valid  = 1'b1;
								res.status = ST_REJECT;
							end else if (len_full == 16'd0) begin
								phase_d    = PH_HEADER;
								res_valid  = 1'b1;
								res.status = ST_EMPTY;
							end else begin
								rem_d   = len_full;
								phase_d = PH_PAYLOAD;
							end
						end
					endcase
				end
				PH_PAYLOAD: begin
					rem_d           = rem_dec;
					res_valid       = 1'b1;
					res.data_byte   = in_byte;
					res.record_last = (rem_dec == 16'd0);
					if (rem_dec == 16'd0) begin
						phase_d = PH_HEADER;
					end
				end
				default: begin
					// stuck until a clear request
					phase_d = phase_q;
				end
			endcase
		end
	end

endmodule

FILE: hw/rtl/tls_record_deframer.sv
// record deframer top level: parser, result register and register port
// output: a result is registered and appears in the cycle after the request that causes it
// throughput: one request per cycle; the parser state updates in a single pass
// input stalls only while the result register is full and the output is stalled
// reset: async active low; parser in header phase, no result held
// reset: max_record_length returns to 16384
`include "assert_macros.svh"

module tls_record_deframer import trd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  cmd,
	input  logic [7:0]            in_byte,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [1:0]            status,
	output logic [7:0]            content_type,
	output logic [7:0]            data_byte,
	output logic                  record_last,
	output logic [15:0]           record_length,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);

	logic        in_accept;
	logic        cfg_write;
	logic [15:0] max_len_q;
	logic        out_valid_q;
	trd_result_t res_d;
	trd_result_t res_q;
	logic        res_valid;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;
	assign prdata    = (paddr[2] == REG_MAX_LEN) ? {16'd0, max_len_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LEN_RESET;
		end else if (cfg_write && paddr[2] == REG_MAX_LEN) begin
			max_len_q <= pwdata[15:0];
		end
	end

	assign in_stall  = out_valid_q && out_stall;
	assign in_accept = in_valid && !in_stall;

	trd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (in_accept),
		.cmd       (cmd),
		.in_byte   (in_byte),
		.max_len   (max_len_q),
		.res_valid (res_valid),
		.res       (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_accept && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept && res_valid) begin
			res_q <= res_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = res_q.status;
	assign content_type  = res_q.content_type;
	assign data_byte     = res_q.data_byte;
	assign record_last   = res_q.record_last;
	assign record_length = res_q.record_length;

	`ASSERT_IMPL(a_stall_needs_result, in_stall, out_valid_q)
	`ASSERT_IMPL(a_data_only_payload, out_valid_q && res_q.status != ST_PAYLOAD,
		res_q.data_byte == 8'd0 && res_q.record_last)
	`ASSERT_NEXT(a_clear_no_result, in_accept && cmd == CMD_CLEAR && !out_valid_q, !out_valid_q)

endmodule

FILE: bench/tb.sv
// self-checking testbench for the tls record deframer
module tb;
	import trd_pkg::*;

	localparam int unsigned ITEMS = 1000;
	localparam int unsigned PHASES = 6;
	localparam int unsigned HOLD_CYCLES = 200;
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam logic [CFG_ADDR_W-1:0] MAX_LEN_ADDR = CFG_ADDR_W'(4 * int'(REG_MAX_LEN));
	localparam logic [CFG_ADDR_W-1:0] SPARE_ADDR = CFG_ADDR_W'(4 * (int'(REG_MAX_LEN) + 1));

	typedef struct packed {
		logic        c;
		logic [7:0]  b;
		bit          typed;
		bit          has;
		trd_result_t res;
	} dir_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic                  cmd = CMD_BYTE;
	logic [7:0]            in_byte = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [1:0]            status;
	logic [7:0]            content_type;
	logic [7:0]            data_byte;
	logic                  record_last;
	logic [15:0]           record_length;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [CFG_ADDR_W-1:0] paddr = '0;
	logic [31:0]           pwdata = '0;
	logic [31:0]           prdata;
	logic                  pready;

	// predictor state
	phase_t      frame_phase = PH_HEADER;
	logic [2:0]  hdr_count = '0;
	logic [7:0]  hdr_type = '0;
	logic [7:0]  ver_hi_byte = '0;
	bit          ver_ok = 1'b0;
	logic [15:0] hdr_len = '0;
	logic [15:0] bytes_left = '0;
	logic [15:0] max_len = MAX_LEN_RESET;

	trd_result_t pending_results[$];
	dir_row_t    dir_rows[$];
	bit          row_typed = 1'b0;
	bit          row_has = 1'b0;
	trd_result_t row_res = '0;
	bit          in_taken = 1'b0;
	bit          hold_req = 1'b0;
	int unsigned idle_pct = 13;
	int unsigned sent_reqs = 0;
	int unsigned fail_count = 0;
	int unsigned cycle_no = 0;

	tls_record_deframer i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd(cmd),
		.in_byte(in_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.content_type(content_type),
		.data_byte(data_byte),
		.record_last(record_last),
		.record_length(record_length),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic trd_result_t mk_res(status_t s, logic [7:0] ct, logic [7:0] db,
			logic last, logic [15:0] len);
		return '{status: s, content_type: ct, data_byte: db, record_last: last,
			record_length: len};
	endfunction

	function automatic void deframe_byte(input logic c, input logic [7:0] b, output bit got,
			output trd_result_t r);
		logic [15:0] ver;
		got = 1'b0;
		r = '0;
		if (c == CMD_CLEAR) begin
			frame_phase = PH_HEADER;
			hdr_count = '0;
			hdr_type = '0;
			ver_hi_byte = '0;
			ver_ok = 1'b0;
			hdr_len = '0;
			bytes_left = '0;
			return;
		end
		case (frame_phase)
			PH_HEADER: begin
				case (hdr_count)
					HDR_TYPE: hdr_type = b;
					HDR_VER_HI: ver_hi_byte = b;
					HDR_VER_LO: begin
						ver = {ver_hi_byte, b};
						ver_ok = (ver >= VER_MIN) && (ver <= VER_MAX);
					end
					HDR_LEN_HI: hdr_len = {8'd0, b};
					default: begin
						hdr_len = {hdr_len[7:0], b};
						if (!ver_ok || hdr_len > max_len) begin
							frame_phase = PH_ERROR;
							got = 1'b1;
							r = mk_res(ST_REJECT, hdr_type, 8'd0, 1'b1, hdr_len);
						end else if (hdr_len == 16'd0) begin
							got = 1'b1;
							r = mk_res(ST_EMPTY, hdr_type, 8'd0, 1'b1, hdr_len);
						end else begin
							bytes_left = hdr_len;
							frame_phase = PH_PAYLOAD;
						end
					end
				endcase
				hdr_count = (hdr_count > HDR_LEN_HI) ? HDR_TYPE : hdr_count + 3'd1;
			end
			PH_PAYLOAD: begin
				bytes_left = bytes_left - 16'd1;
				got = 1'b1;
				r = mk_res(ST_PAYLOAD, hdr_type, b, bytes_left == 16'd0, hdr_len);
				if (bytes_left == 16'd0)
					frame_phase = PH_HEADER;
			end
			default: ;
		endcase
	endfunction

	always @(posedge clk) begin
		trd_result_t want;
		bit got;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("result with no request pending: status %0d data %0h", status, data_byte);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (status != want.status) begin
					$error("status exp %0d got %0d", want.status, status);
					fail_count++;
				end
				if (content_type != want.content_type) begin
					$error("content_type exp %0h got %0h", want.content_type, content_type);
					fail_count++;
				end
				if (data_byte != want.data_byte) begin
					$error("data_byte exp %0h got %0h", want.data_byte, data_byte);
					fail_count++;
				end
				if (record_last != want.record_last) begin
					$error("record_last exp %0d got %0d", want.record_last, record_last);
					fail_count++;
				end
				if (record_length != want.record_length) begin
					$error("record_length exp %0d got %0d", want.record_length, record_length);
					fail_count++;
				end
			end
		end
		in_taken = arst_n && in_valid && !in_stall;
		if (in_taken) begin
			deframe_byte(cmd, in_byte, got, want);
			if (row_typed) begin
				got = row_has;
				want = row_res;
			end
			if (got)
				pending_results.push_back(want);
		end
	end

	always @(posedge clk) begin
		cycle_no++;
		if (cycle_no > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
				out_stall <= 1'b0;
			end else begin
				out_stall <= (idle_pct != 0) && ($urandom_range(99) < idle_pct);
			end
		end
	end

	task automatic push_req(input logic c, input logic [7:0] b);
		int unsigned gap;
		if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			gap = $urandom_range(3, 1);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		in_byte <= b;
		do @(negedge clk); while (!in_taken);
		sent_reqs++;
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic reg_write(input logic [CFG_ADDR_W-1:0] a, input logic [15:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= a;
		pwdata <= {16'($urandom), v};
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (a == MAX_LEN_ADDR)
			max_len = v;
	endtask

	task automatic add_row(input logic c, input logic [7:0] b, input bit typed, input bit has,
			input trd_result_t res);
		dir_rows.push_back('{c: c, b: b, typed: typed, has: has, res: res});
	endtask

	task automatic send_record();
		int unsigned pick, n;
		logic [7:0] ctype;
		logic [15:0] ver, len;
		pick = $urandom_range(99);
		ctype = 8'($urandom);
		ver = VER_MIN + 16'($urandom_range(3));
		len = 16'($urandom_range((max_len < 16'd12) ? max_len : 12));
		if (pick < 12) begin
			if ($urandom_range(1) == 0 || max_len == 16'hFFFF)
				ver = 16'($urandom);
			else
				len = max_len + 16'd1 + 16'($urandom_range(16'hFFFF - max_len - 1));
		end else if (pick < 20) begin
			len = 16'($urandom_range(max_len));
		end else if (pick < 28) begin
			// noise, then a clear to resync
			n = $urandom_range(5, 1);
			repeat (n) push_req(1'($urandom_range(1)), 8'($urandom));
			push_req(CMD_CLEAR, 8'($urandom));
			return;
		end
		push_req(CMD_BYTE, ctype);
		push_req(CMD_BYTE, ver[15:8]);
		push_req(CMD_BYTE, ver[7:0]);
		push_req(CMD_BYTE, len[15:8]);
		push_req(CMD_BYTE, len[7:0]);
		if (pick < 12) begin
			n = $urandom_range(3);
			repeat (n) push_req(CMD_BYTE, 8'($urandom));
			push_req(CMD_CLEAR, 8'($urandom));
		end else begin
			n = (pick < 20) ? $urandom_range(10) : int'(len);
			repeat (n) push_req(CMD_BYTE, 8'($urandom));
			if (pick < 20 || $urandom_range(9) == 0)
				push_req(CMD_CLEAR, 8'($urandom));
		end
	endtask

	initial begin
		int unsigned target;
		bit paused;
		logic [15:0] cap;
		paused = 1'b0;

		// good record of two bytes
		add_row(CMD_BYTE, 8'h17, 0, 0, '0);
		add_row(CMD_BYTE, 8'h03, 0, 0, '0);
		add_row(CMD_BYTE, 8'h03, 0, 0, '0);
		add_row(CMD_BYTE, 8'h00, 0, 0, '0);
		add_row(CMD_BYTE, 8'h02, 0, 0, '0);
		add_row(CMD_BYTE, 8'h00, 1, 1, mk_res(ST_PAYLOAD, 8'h17, 8'h00, 1'b0, 16'd2));
		add_row(CMD_BYTE, 8'hFF, 1, 1, mk_res(ST_PAYLOAD, 8'h17, 8'hFF, 1'b1, 16'd2));
		// empty record
		add_row(CMD_BYTE, 8'hFF, 0, 0, '0);
		add_row(CMD_BYTE, 8'h03, 0, 0, '0);
		add_row(CMD_BYTE, 8'h01, 0, 0, '0);
		add_row(CMD_BYTE, 8'h00, 0, 0, '0);
		add_row(CMD_BYTE, 8'h00, 1, 1, mk_res(ST_EMPTY, 8'hFF, 8'h00, 1'b1, 16'd0));
		// version out of range, then stuck until clear
		add_row(CMD_BYTE, 8'h00, 0, 0, '0);
		add_row(CMD_BYTE, 8'h03, 0, 0, '0);
		add_row(CMD_BYTE, 8'h05, 0, 0, '0);
		add_row(CMD_BYTE, 8'h00, 0, 0, '0);
		add_row(CMD_BYTE, 8'h01, 1, 1, mk_res(ST_REJECT, 8'h00, 8'h00, 1'b1, 16'd1));
		add_row(CMD_BYTE, 8'hAA, 1, 0, '0);
		add_row(CMD_CLEAR, 8'hFF, 1, 0, '0);
		// length one above the reset maximum
		add_row(CMD_BYTE, 8'h16, 0, 0, '0);
		add_row(CMD_BYTE, 8'h03, 0, 0, '0);
		add_row(CMD_BYTE, 8'h04, 0, 0, '0);
		add_row(CMD_BYTE, 8'h40, 0, 0, '0);
		add_row(CMD_BYTE, 8'h01, 1, 1, mk_res(ST_REJECT, 8'h16, 8'h00, 1'b1, 16'h4001));
		add_row(CMD_CLEAR, 8'h00, 1, 0, '0);

		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_rows[i]) begin
			row_typed = dir_rows[i].typed;
			row_has = dir_rows[i].has;
			row_res = dir_rows[i].res;
			push_req(dir_rows[i].c, dir_rows[i].b);
		end
		row_typed = 1'b0;

		target = sent_reqs;
		for (int unsigned p = 0; p < PHASES; p++) begin
			settle();
			case (p)
				0: cap = 16'hFFFF;
				1: cap = 16'd0;
				2: cap = MAX_LEN_RESET;
				3: cap = 16'($urandom_range(20, 2));
				4: cap = 16'd1;
				default: cap = 16'($urandom);
			endcase
			if (p == 1)
				reg_write(SPARE_ADDR, 16'($urandom));
			reg_write(MAX_LEN_ADDR, cap);
			idle_pct = (p == 0) ? 0 : 13;
			if (p == 2)
				hold_req = 1'b1;
			target += ITEMS / PHASES;
			while (sent_reqs < target) begin
				send_record();
				if (p == 3 && !paused && sent_reqs + ITEMS / (2 * PHASES) > target) begin
					settle();
					paused = 1'b1;
				end
			end
		end

		settle();
		repeat (8) @(negedge clk);
		if (fail_count == 0 && pending_results.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
